// ===== hdl/asg_pkg.sv =====
// Shared types and constants of the allreduce schedule generator.
// Depends on nothing; every other file of the block uses it by scoped names.

package asg_pkg;

    // Widths fixed by the transaction formats.
    localparam int RANK_BITS_DEF = 16;
    localparam int PEER_W        = 16;
    localparam int CFG_DATA_W    = 16;
    localparam int CFG_IDX_W     = 2;
    localparam int SEQ_W         = 16;
    localparam int COUNT_W       = 32;
    localparam int CODE_W        = 8;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_GROUP_SIZE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MY_RANK    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CONTEXT_ID = 2'd2;

    // Buffer selectors.
    localparam logic BUF_SEND = 1'b0;
    localparam logic BUF_RECV = 1'b1;

    typedef enum logic [1:0] {
        ACT_SEND   = 2'd0,
        ACT_RECV   = 2'd1,
        ACT_REDUCE = 2'd2,
        ACT_COPY   = 2'd3
    } t_action;

    typedef enum logic {
        ALU_ADD = 1'b0,
        ALU_SUB = 1'b1
    } t_alu_op;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHECK,
        ST_POF2,
        ST_REM,
        ST_FOLDCHK,
        ST_NEWID,
        ST_FOLD,
        ST_RCMP,
        ST_RDEST,
        ST_RDIR,
        ST_REMIT,
        ST_UNFOLD
    } t_state;

    typedef struct packed {
        logic [COUNT_W-1:0] element_count;
        logic [CODE_W-1:0]  data_type;
        logic [CODE_W-1:0]  reduce_op;
    } t_req;

    typedef struct packed {
        t_action            action;
        logic [PEER_W-1:0]  peer_rank;
        logic               read_buffer;
        logic               write_buffer;
        logic               barrier;
        logic [31:0]        collective_id;
        logic [COUNT_W-1:0] count_out;
        logic [CODE_W-1:0]  type_out;
        logic [CODE_W-1:0]  op_out;
        logic               last;
    } t_act;

    typedef struct packed {
        logic [CFG_IDX_W-1:0]  index;
        logic [CFG_DATA_W-1:0] data;
    } t_cfg;

    // One action as issued by the sequencer.
    typedef struct packed {
        logic              valid;
        t_action           action;
        logic [PEER_W-1:0] peer;
        logic              rd;
        logic              wr;
        logic              bar;
        logic              last;
    } t_emit;

endpackage

// ===== hdl/asg_req_if.sv =====
// Request channel: one allreduce request per transaction.
// Depends on asg_pkg.

interface asg_req_if;
    logic          valid;
    logic          ready;
    asg_pkg::t_req payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ===== hdl/asg_act_if.sv =====
// Action channel: one schedule action per transaction.
// Depends on asg_pkg.

interface asg_act_if;
    logic          valid;
    logic          ready;
    asg_pkg::t_act payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ===== hdl/asg_cfg_if.sv =====
// Configuration write channel: register index and write data.
// Depends on asg_pkg.

interface asg_cfg_if;
    logic          valid;
    logic          ready;
    asg_pkg::t_cfg payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ===== hdl/allreduce_schedule_generator_unit.sv =====
// Top level of the recursive-doubling allreduce schedule generator.
// Depends on asg_pkg, the three channel interfaces, asg_seq and asg_alu.
//
//  channel | dir | carries
//  i_req   | in  | element_count, data_type, reduce_op
//  o_act   | out | one schedule action, last set on the final one of a request
//  i_cfg   | in  | register index and write data, ready whenever out of reset
//
// After acceptance a request runs setup: check, search for P (largest power of two
// not above group_size), remainder, fold check and, outside the fold, a new id. Each
// round finds its partner and issues 3 or 4 actions. A request that emits nothing
// leaves from the check state. Rank adds, subtracts and less-than compares use the
// adder in asg_alu; actions leave via an output register that refills as it empties.
// Synchronous reset holds both inputs not ready; a stalled output holds the sequencer.

module allreduce_schedule_generator_unit #(
    parameter int RANK_BITS = asg_pkg::RANK_BITS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    asg_req_if.sink       i_req,
    asg_act_if.source     o_act,
    asg_cfg_if.sink       i_cfg
);

    logic [RANK_BITS-1:0]          r_group_size;
    logic [RANK_BITS-1:0]          r_my_rank;
    logic [asg_pkg::SEQ_W-1:0]     r_context_id;
    logic [asg_pkg::SEQ_W-1:0]     r_seq;
    asg_pkg::t_req                 r_req;
    logic [31:0]                   r_id;
    logic                          r_out_valid;
    asg_pkg::t_act                 r_out;

    logic                          w_busy;
    logic                          w_start;
    logic                          w_slot_free;
    asg_pkg::t_emit                w_emit;
    logic [RANK_BITS:0]            w_alu_a;
    logic [RANK_BITS:0]            w_alu_b;
    asg_pkg::t_alu_op              w_alu_op;
    logic [RANK_BITS:0]            w_alu_result;
    logic                          w_alu_lt;

    // Neither input takes a transaction while reset is asserted.
    assign i_cfg.ready   = i_rst_n;
    assign i_req.ready   = ~w_busy & i_rst_n;
    assign w_start       = i_req.valid & ~w_busy & i_rst_n;
    assign w_slot_free   = ~r_out_valid | o_act.ready;
    assign o_act.valid   = r_out_valid;
    assign o_act.payload = r_out;

    // Configuration registers; rank values keep only the rank bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_group_size <= RANK_BITS'(1);
            r_my_rank    <= '0;
            r_context_id <= '0;
        end else if (i_cfg.valid) begin
            case (i_cfg.payload.index)
                asg_pkg::CFG_GROUP_SIZE: r_group_size <= i_cfg.payload.data[RANK_BITS-1:0];
                asg_pkg::CFG_MY_RANK:    r_my_rank    <= i_cfg.payload.data[RANK_BITS-1:0];
                asg_pkg::CFG_CONTEXT_ID: r_context_id <= i_cfg.payload.data;
                default: begin
                end
            endcase
        end
    end

    // Sequence number advances on every request, including empty ones.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seq <= '0;
        end else if (w_start) begin
            r_seq <= r_seq + 1'b1;
        end
        if (w_start) begin
            r_req <= i_req.payload;
            r_id  <= {r_context_id, r_seq};
        end
    end

    // Output register: loads an issued action when the slot is free.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_slot_free) begin
            r_out_valid <= w_emit.valid;
        end
        if (w_slot_free && w_emit.valid) begin
            r_out.action        <= w_emit.action;
            r_out.peer_rank     <= w_emit.peer;
            r_out.read_buffer   <= w_emit.rd;
            r_out.write_buffer  <= w_emit.wr;
            r_out.barrier       <= w_emit.bar;
            r_out.collective_id <= r_id;
            r_out.count_out     <= r_req.element_count;
            r_out.type_out      <= r_req.data_type;
            r_out.op_out        <= (w_emit.action == asg_pkg::ACT_REDUCE) ?
                                   r_req.reduce_op : '0;
            r_out.last          <= w_emit.last;
        end
    end

    asg_seq #(
        .RANK_BITS (RANK_BITS)
    ) u_seq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (w_start),
        .i_group_size (r_group_size),
        .i_my_rank    (r_my_rank),
        .i_slot_free  (w_slot_free),
        .o_busy       (w_busy),
        .o_emit       (w_emit),
        .o_alu_a      (w_alu_a),
        .o_alu_b      (w_alu_b),
        .o_alu_op     (w_alu_op),
        .i_alu_result (w_alu_result),
        .i_alu_lt     (w_alu_lt)
    );

    asg_alu #(
        .WIDTH (RANK_BITS + 1)
    ) u_alu (
        .i_a      (w_alu_a),
        .i_b      (w_alu_b),
        .i_op     (w_alu_op),
        .o_result (w_alu_result),
        .o_lt     (w_alu_lt)
    );

endmodule

// ===== hdl/asg_alu.sv =====
// Shared add/subtract and compare unit used by the schedule sequencer.
// Depends on asg_pkg for the operation codes.

module asg_alu #(
    parameter int WIDTH = asg_pkg::RANK_BITS_DEF + 1
) (
    input  logic [WIDTH-1:0] i_a,
    input  logic [WIDTH-1:0] i_b,
    input  asg_pkg::t_alu_op i_op,
    output logic [WIDTH-1:0] o_result,
    output logic             o_lt
);

    logic             w_sub;
    logic [WIDTH-1:0] w_b;
    logic [WIDTH:0]   w_sum;

    // One adder; subtraction through the inverted operand and a carry in.
    assign w_sub    = (i_op == asg_pkg::ALU_SUB);
    assign w_b      = w_sub ? ~i_b : i_b;
    assign w_sum    = {1'b0, i_a} + {1'b0, w_b} + {{WIDTH{1'b0}}, w_sub};
    assign o_result = w_sum[WIDTH-1:0];
    // No carry out of a subtraction means a borrow, so a < b.
    assign o_lt     = w_sub & ~w_sum[WIDTH];

endmodule

// ===== hdl/asg_seq.sv =====
// Schedule sequencer: walks fold, exchange rounds and unfold, one action per step.
// Depends on asg_pkg; drives the shared asg_alu through its operand ports.

module asg_seq #(
    parameter int RANK_BITS = asg_pkg::RANK_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_start,
    input  logic [RANK_BITS-1:0]   i_group_size,
    input  logic [RANK_BITS-1:0]   i_my_rank,
    input  logic                   i_slot_free,
    output logic                   o_busy,
    output asg_pkg::t_emit         o_emit,
    output logic [RANK_BITS:0]     o_alu_a,
    output logic [RANK_BITS:0]     o_alu_b,
    output asg_pkg::t_alu_op       o_alu_op,
    input  logic [RANK_BITS:0]     i_alu_result,
    input  logic                   i_alu_lt
);

    localparam int W  = RANK_BITS + 1;
    localparam int PW = asg_pkg::PEER_W;

    asg_pkg::t_state      r_state,    n_state;
    logic [RANK_BITS-1:0] r_pof2,     n_pof2;
    logic [RANK_BITS-1:0] r_rem,      n_rem;
    logic [RANK_BITS-1:0] r_mask,     n_mask;
    logic [RANK_BITS-1:0] r_new_id,   n_new_id;
    logic [RANK_BITS-1:0] r_peer_id,  n_peer_id;
    logic [RANK_BITS-1:0] r_dest,     n_dest;
    logic                 r_folded,   n_folded;
    logic                 r_lower,    n_lower;
    logic [1:0]           r_sub,      n_sub;

    logic [RANK_BITS-1:0] w_xor_dest;
    logic [RANK_BITS-1:0] w_rank_up;
    logic [RANK_BITS-1:0] w_rank_down;
    logic                 w_final_round;
    logic                 w_odd;

    // Neighbours of a folded rank differ only in the lowest bit.
    assign w_odd         = i_my_rank[0];
    assign w_rank_up     = i_my_rank | RANK_BITS'(1);
    assign w_rank_down   = i_my_rank & ~RANK_BITS'(1);
    assign w_xor_dest    = r_new_id ^ r_mask;
    assign w_final_round = ({r_mask, 1'b0} == W'(r_pof2));
    assign o_busy        = (r_state != asg_pkg::ST_IDLE);

    // State and working registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= asg_pkg::ST_IDLE;
            r_sub   <= '0;
        end else begin
            r_state <= n_state;
            r_sub   <= n_sub;
        end
        r_pof2     <= n_pof2;
        r_rem      <= n_rem;
        r_mask     <= n_mask;
        r_new_id   <= n_new_id;
        r_peer_id  <= n_peer_id;
        r_dest     <= n_dest;
        r_folded   <= n_folded;
        r_lower    <= n_lower;
    end

    // Next state, shared unit operands and the action to issue.
    always_comb begin
        n_state    = r_state;
        n_pof2     = r_pof2;
        n_rem      = r_rem;
        n_mask     = r_mask;
        n_new_id   = r_new_id;
        n_peer_id  = r_peer_id;
        n_dest     = r_dest;
        n_folded   = r_folded;
        n_lower    = r_lower;
        n_sub      = r_sub;
        o_alu_a    = W'(i_my_rank);
        o_alu_b    = W'(i_group_size);
        o_alu_op   = asg_pkg::ALU_SUB;
        o_emit     = '0;

        case (r_state)
            asg_pkg::ST_IDLE: begin
                if (i_start) begin
                    n_state = asg_pkg::ST_CHECK;
                end
            end

            // Rank inside the group and more than one member.
            asg_pkg::ST_CHECK: begin
                if ((i_group_size[RANK_BITS-1:1] == '0) || !i_alu_lt) begin
                    n_state = asg_pkg::ST_IDLE;
                end else begin
                    n_pof2  = RANK_BITS'(1);
                    n_state = asg_pkg::ST_POF2;
                end
            end

            // Largest power of two not above the group size, one doubling a cycle.
            asg_pkg::ST_POF2: begin
                o_alu_a = W'(i_group_size);
                o_alu_b = {r_pof2, 1'b0};
                if (i_alu_lt) begin
                    n_state = asg_pkg::ST_REM;
                end else begin
                    n_pof2 = {r_pof2[RANK_BITS-2:0], 1'b0};
                end
            end

            asg_pkg::ST_REM: begin
                o_alu_a = W'(i_group_size);
                o_alu_b = W'(r_pof2);
                n_rem   = i_alu_result[RANK_BITS-1:0];
                n_state = asg_pkg::ST_FOLDCHK;
            end

            // Ranks below twice the excess take part in the fold.
            asg_pkg::ST_FOLDCHK: begin
                o_alu_b  = {r_rem, 1'b0};
                n_folded = i_alu_lt;
                n_sub    = '0;
                if (i_alu_lt) begin
                    n_new_id = i_my_rank >> 1;
                    n_state  = asg_pkg::ST_FOLD;
                end else begin
                    n_state = asg_pkg::ST_NEWID;
                end
            end

            asg_pkg::ST_NEWID: begin
                o_alu_b  = W'(r_rem);
                n_new_id = i_alu_result[RANK_BITS-1:0];
                n_mask   = RANK_BITS'(1);
                n_state  = asg_pkg::ST_RCMP;
            end

            asg_pkg::ST_FOLD: begin
                o_emit.valid = 1'b1;
                o_emit.bar   = 1'b1;
                if (!w_odd) begin
                    o_emit.action = asg_pkg::ACT_SEND;
                    o_emit.peer   = PW'(w_rank_up);
                    o_emit.rd     = asg_pkg::BUF_SEND;
                    if (i_slot_free) begin
                        n_state = asg_pkg::ST_UNFOLD;
                    end
                end else if (r_sub == 2'd0) begin
                    o_emit.action = asg_pkg::ACT_RECV;
                    o_emit.peer   = PW'(w_rank_down);
                    o_emit.wr     = asg_pkg::BUF_RECV;
                    if (i_slot_free) begin
                        n_sub = 2'd1;
                    end
                end else begin
                    o_emit.action = asg_pkg::ACT_REDUCE;
                    o_emit.rd     = asg_pkg::BUF_RECV;
                    o_emit.wr     = asg_pkg::BUF_SEND;
                    if (i_slot_free) begin
                        n_sub   = '0;
                        n_mask  = RANK_BITS'(1);
                        n_state = asg_pkg::ST_RCMP;
                    end
                end
            end

            // Partner in the folded numbering: below the excess maps to 2d+1.
            asg_pkg::ST_RCMP: begin
                o_alu_a    = W'(w_xor_dest);
                o_alu_b    = W'(r_rem);
                n_peer_id  = w_xor_dest;
                if (i_alu_lt) begin
                    n_dest  = {w_xor_dest[RANK_BITS-2:0], 1'b1};
                    n_state = asg_pkg::ST_RDIR;
                end else begin
                    n_state = asg_pkg::ST_RDEST;
                end
            end

            asg_pkg::ST_RDEST: begin
                o_alu_a  = W'(r_peer_id);
                o_alu_b  = W'(r_rem);
                o_alu_op = asg_pkg::ALU_ADD;
                n_dest   = i_alu_result[RANK_BITS-1:0];
                n_state  = asg_pkg::ST_RDIR;
            end

            asg_pkg::ST_RDIR: begin
                o_alu_a = W'(r_dest);
                o_alu_b = W'(i_my_rank);
                n_lower = i_alu_lt;
                n_sub   = '0;
                n_state = asg_pkg::ST_REMIT;
            end

            // Receive, send, reduce and, towards a higher partner, copy.
            asg_pkg::ST_REMIT: begin
                o_emit.valid = 1'b1;
                o_emit.bar   = 1'b1;
                case (r_sub)
                    2'd0: begin
                        o_emit.action = asg_pkg::ACT_RECV;
                        o_emit.peer   = PW'(r_dest);
                        o_emit.wr     = asg_pkg::BUF_RECV;
                        o_emit.bar    = 1'b0;
                    end
                    2'd1: begin
                        o_emit.action = asg_pkg::ACT_SEND;
                        o_emit.peer   = PW'(r_dest);
                        o_emit.rd     = asg_pkg::BUF_SEND;
                    end
                    2'd2: begin
                        o_emit.action = asg_pkg::ACT_REDUCE;
                        o_emit.rd     = r_lower ? asg_pkg::BUF_RECV : asg_pkg::BUF_SEND;
                        o_emit.wr     = r_lower ? asg_pkg::BUF_SEND : asg_pkg::BUF_RECV;
                        o_emit.last   = r_lower & w_final_round & ~r_folded;
                    end
                    default: begin
                        o_emit.action = asg_pkg::ACT_COPY;
                        o_emit.rd     = asg_pkg::BUF_RECV;
                        o_emit.wr     = asg_pkg::BUF_SEND;
                        o_emit.last   = w_final_round & ~r_folded;
                    end
                endcase
                if (i_slot_free) begin
                    if ((r_sub == 2'd3) || ((r_sub == 2'd2) && r_lower)) begin
                        n_sub = '0;
                        if (w_final_round) begin
                            n_state = r_folded ? asg_pkg::ST_UNFOLD : asg_pkg::ST_IDLE;
                        end else begin
                            n_mask  = {r_mask[RANK_BITS-2:0], 1'b0};
                            n_state = asg_pkg::ST_RCMP;
                        end
                    end else begin
                        n_sub = r_sub + 2'd1;
                    end
                end
            end

            // Hand the result back to the even neighbour that folded away.
            asg_pkg::ST_UNFOLD: begin
                o_emit.valid = 1'b1;
                o_emit.bar   = 1'b1;
                o_emit.last  = 1'b1;
                if (w_odd) begin
                    o_emit.action = asg_pkg::ACT_SEND;
                    o_emit.peer   = PW'(w_rank_down);
                end else begin
                    o_emit.action = asg_pkg::ACT_RECV;
                    o_emit.peer   = PW'(w_rank_up);
                end
                o_emit.rd = asg_pkg::BUF_SEND;
                o_emit.wr = asg_pkg::BUF_SEND;
                if (i_slot_free) begin
                    n_state = asg_pkg::ST_IDLE;
                end
            end

            default: begin
                n_state = asg_pkg::ST_IDLE;
            end
        endcase
    end

endmodule
